// ----- sv/hmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmr_pkg
// shared widths, fixed-point constants, model codes and the pipeline item
// ----------------------------------------------------------------------------
package hmr_pkg;

    localparam int IN_W  = 16;          // width of every input field
    localparam int OUT_W = 8;           // width of every result channel
    localparam int FRAC  = 16;          // fractional bits of internal values
    localparam int Q_W   = FRAC + 1;    // unsigned q.16 holding 0.0 .. 1.0
    localparam int DIV_STEPS = Q_W;     // one quotient bit per divider stage

    localparam logic [Q_W-1:0] ONE  = 17'h10000;
    localparam logic [Q_W-1:0] HALF = 17'h08000;

    // luma weights, truncated q0.16
    localparam logic [15:0] LUMA_R = 16'd19595;
    localparam logic [15:0] LUMA_G = 16'd38469;
    localparam logic [15:0] LUMA_B = 16'd7471;

    // color_model register codes (code 3 behaves as hsv)
    localparam logic [1:0] MODEL_HSV = 2'd0;
    localparam logic [1:0] MODEL_HSL = 2'd1;
    localparam logic [1:0] MODEL_HCY = 2'd2;

    typedef struct packed {
        logic [1:0]            model;
        logic [Q_W-1:0]        sat;
        logic [Q_W-1:0]        lvl;
        logic [OUT_W-1:0]      alpha;
        logic [2:0][Q_W-1:0]   ramp;
        logic [2:0][Q_W-1:0]   hsv_u;
        logic [Q_W-1:0]        hsl_c;
        logic [Q_W-1:0]        luma;
    } t_item;

endpackage

// ----- sv/hmr_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmr_in_if
// input item channel: hue, saturation, level, alpha with valid/ready
// ----------------------------------------------------------------------------
interface hmr_in_if;
    logic                     valid;
    logic                     ready;
    logic [hmr_pkg::IN_W-1:0] hue;
    logic [hmr_pkg::IN_W-1:0] saturation;
    logic [hmr_pkg::IN_W-1:0] level;
    logic [hmr_pkg::IN_W-1:0] alpha_in;

    modport source (output valid, hue, saturation, level, alpha_in, input ready);
    modport sink   (input valid, hue, saturation, level, alpha_in, output ready);
endinterface

// ----- sv/hmr_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmr_out_if
// result item channel: 8-bit rgba with valid/ready
// ----------------------------------------------------------------------------
interface hmr_out_if;
    logic                      valid;
    logic                      ready;
    logic [hmr_pkg::OUT_W-1:0] red;
    logic [hmr_pkg::OUT_W-1:0] green;
    logic [hmr_pkg::OUT_W-1:0] blue;
    logic [hmr_pkg::OUT_W-1:0] alpha_out;

    modport source (output valid, red, green, blue, alpha_out, input ready);
    modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

// ----- sv/hmr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmr_div
// pipelined restoring divider, (num << 16) / den with num <= den,
// one quotient bit per stage, item travels alongside
// ----------------------------------------------------------------------------
module hmr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [hmr_pkg::Q_W-1:0]    i_num,
    input  logic [hmr_pkg::Q_W-1:0]    i_den,
    input  hmr_pkg::t_item             i_item,
    output logic                       o_vld,
    output logic [hmr_pkg::Q_W-1:0]    o_quo,
    output hmr_pkg::t_item             o_item
);

    logic                    r_vld  [hmr_pkg::DIV_STEPS];
    logic [hmr_pkg::Q_W-1:0] r_rem  [hmr_pkg::DIV_STEPS];
    logic [hmr_pkg::Q_W-1:0] r_den  [hmr_pkg::DIV_STEPS];
    logic [hmr_pkg::Q_W-1:0] r_quo  [hmr_pkg::DIV_STEPS];
    hmr_pkg::t_item          r_item [hmr_pkg::DIV_STEPS];

    for (genvar k = 0; k < hmr_pkg::DIV_STEPS; k++) begin : g_step
        logic                    n_vld_in;
        logic [hmr_pkg::Q_W:0]   n_trial;
        logic [hmr_pkg::Q_W-1:0] n_den;
        logic [hmr_pkg::Q_W-1:0] n_quo_in;
        hmr_pkg::t_item          n_item;
        logic                    n_ge;
        logic [hmr_pkg::Q_W:0]   n_diff;

        if (k == 0) begin : g_first
            // top quotient bit: remainder is the numerator itself
            assign n_vld_in = i_vld;
            assign n_trial  = {1'b0, i_num};
            assign n_den    = i_den;
            assign n_quo_in = '0;
            assign n_item   = i_item;
        end else begin : g_next
            assign n_vld_in = r_vld[k-1];
            assign n_trial  = {r_rem[k-1], 1'b0};
            assign n_den    = r_den[k-1];
            assign n_quo_in = r_quo[k-1];
            assign n_item   = r_item[k-1];
        end

        assign n_diff = n_trial - {1'b0, n_den};
        assign n_ge   = (n_trial >= {1'b0, n_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= n_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? n_diff[hmr_pkg::Q_W-1:0] : n_trial[hmr_pkg::Q_W-1:0];
                r_den[k]  <= n_den;
                r_quo[k]  <= {n_quo_in[hmr_pkg::Q_W-2:0], n_ge};
                r_item[k] <= n_item;
            end
        end
    end

    assign o_vld  = r_vld[hmr_pkg::DIV_STEPS-1];
    assign o_quo  = r_quo[hmr_pkg::DIV_STEPS-1];
    assign o_item = r_item[hmr_pkg::DIV_STEPS-1];

endmodule

// ----- sv/hue_model_to_rgb8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hue_model_to_rgb8
// hue / saturation-or-chroma / level / alpha to 8-bit rgba, hsv, hsl or hcy
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns one
// rgba item per item, in order. The pipeline depth is set by the hcy
// chroma rescale: a 17-stage divider producing one quotient bit per stage,
// plus five stages ahead of it (input scaling, hue ramp, products, luma
// sum, divide setup) and four after it (chroma product, channel product,
// truncation and offset, 8-bit scaling). All stages advance together;
// when the output item is not taken the whole pipe holds. color_model is
// sampled with each item on entry; write it only while the block is empty.
// All inputs are q0.16 fractions with all ones meaning 1.0, hue wraps at
// one turn; outputs are floor(x*255) saturated to 0..255.
// ----------------------------------------------------------------------------
module hue_model_to_rgb8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    hmr_in_if.sink      i_pix,
    hmr_out_if.source   o_pix
);

    localparam logic signed [20:0] ONE_S   = 21'sd65536;
    localparam logic signed [20:0] TWO_S   = 21'sd131072;
    localparam logic signed [20:0] THREE_S = 21'sd196608;
    localparam logic signed [20:0] FOUR_S  = 21'sd262144;
    localparam logic signed [17:0] HALF_S  = 18'sd32768;

    // input fraction: all ones maps to exactly 1.0
    function automatic logic [16:0] frac_in(input logic [15:0] x);
        return {1'b0, x} + 17'(x == 16'hffff);
    endfunction

    function automatic logic signed [20:0] abs21(input logic signed [20:0] x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic [16:0] clamp_one(input logic signed [20:0] x);
        logic [16:0] v;
        if (x < 0) begin
            v = '0;
        end else if (x > ONE_S) begin
            v = hmr_pkg::ONE;
        end else begin
            v = x[16:0];
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [1:0] r_color_model;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_model <= hmr_pkg::MODEL_HSV;
        end else if (i_cfg_wr_en) begin
            r_color_model <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // flow control: every stage moves when the output slot is free
    // ------------------------------------------------------------------
    logic w_en;
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    logic r_s6_vld, r_s7_vld, r_s8_vld, r_s9_vld;
    logic w_div_vld;

    assign w_en        = !r_s9_vld || o_pix.ready;
    assign i_pix.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
            r_s8_vld <= 1'b0;
            r_s9_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_pix.valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= w_div_vld;
            r_s7_vld <= r_s6_vld;
            r_s8_vld <= r_s7_vld;
            r_s9_vld <= r_s8_vld;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input scaling, alpha finished here
    // ------------------------------------------------------------------
    logic [15:0] r_s1_hue;
    logic [16:0] r_s1_sat, r_s1_lvl;
    logic [7:0]  r_s1_alpha;
    logic [1:0]  r_s1_model;
    logic [16:0] w_alpha_q;
    logic [24:0] w_alpha_x255;

    assign w_alpha_q    = frac_in(i_pix.alpha_in);
    // alpha * 255 as (alpha << 8) - alpha, never above 1.0 so no clamp
    assign w_alpha_x255 = {w_alpha_q, 8'b0} - 25'(w_alpha_q);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_hue   <= i_pix.hue;
            r_s1_sat   <= frac_in(i_pix.saturation);
            r_s1_lvl   <= frac_in(i_pix.level);
            r_s1_alpha <= w_alpha_x255[23:16];
            r_s1_model <= r_color_model;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: hue ramp and hsl chroma factor 1-|2l-1|
    // ------------------------------------------------------------------
    hmr_pkg::t_item r_s2_item;
    logic [16:0]    r_s2_k;
    logic signed [20:0] w_h6;
    logic signed [20:0] w_two_l;
    logic signed [20:0] w_k;

    // 6h as 4h + 2h
    assign w_h6    = $signed({3'b000, r_s1_hue, 2'b00}) + $signed({4'b0000, r_s1_hue, 1'b0});
    assign w_two_l = $signed({3'b000, r_s1_lvl, 1'b0}) - ONE_S;
    assign w_k     = ONE_S - abs21(w_two_l);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_item.model   <= r_s1_model;
            r_s2_item.sat     <= r_s1_sat;
            r_s2_item.lvl     <= r_s1_lvl;
            r_s2_item.alpha   <= r_s1_alpha;
            r_s2_item.ramp[0] <= clamp_one(abs21(w_h6 - THREE_S) - ONE_S);
            r_s2_item.ramp[1] <= clamp_one(TWO_S - abs21(w_h6 - TWO_S));
            r_s2_item.ramp[2] <= clamp_one(TWO_S - abs21(w_h6 - FOUR_S));
            r_s2_item.hsv_u   <= '0;
            r_s2_item.hsl_c   <= '0;
            r_s2_item.luma    <= '0;
            r_s2_k            <= w_k[16:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: products (1-ramp)*s, ramp*weight, k*s
    // ------------------------------------------------------------------
    hmr_pkg::t_item r_s3_item;
    logic [33:0]    r_s3_pu [3];
    logic [32:0]    r_s3_pw [3];
    logic [33:0]    r_s3_pk;
    logic [16:0]    w_inv   [3];
    logic [15:0]    w_wt    [3];

    assign w_wt[0] = hmr_pkg::LUMA_R;
    assign w_wt[1] = hmr_pkg::LUMA_G;
    assign w_wt[2] = hmr_pkg::LUMA_B;

    for (genvar i = 0; i < 3; i++) begin : g_s3
        assign w_inv[i] = hmr_pkg::ONE - r_s2_item.ramp[i];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s3_pu[i] <= 34'(w_inv[i]) * 34'(r_s2_item.sat);
                r_s3_pw[i] <= 33'(r_s2_item.ramp[i]) * 33'(w_wt[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_item <= r_s2_item;
            r_s3_pk   <= 34'(r_s2_k) * 34'(r_s2_item.sat);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: hsv factor, luma sum, hsl chroma
    // ------------------------------------------------------------------
    hmr_pkg::t_item r_s4_item;
    hmr_pkg::t_item n_s4_item;
    logic [34:0]    w_luma_sum;

    assign w_luma_sum = 35'(r_s3_pw[0]) + 35'(r_s3_pw[1]) + 35'(r_s3_pw[2]);

    always_comb begin
        n_s4_item          = r_s3_item;
        n_s4_item.hsv_u[0] = hmr_pkg::ONE - r_s3_pu[0][32:16];
        n_s4_item.hsv_u[1] = hmr_pkg::ONE - r_s3_pu[1][32:16];
        n_s4_item.hsv_u[2] = hmr_pkg::ONE - r_s3_pu[2][32:16];
        n_s4_item.hsl_c    = r_s3_pk[32:16];
        n_s4_item.luma     = w_luma_sum[32:16];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_item <= n_s4_item;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: divide setup, y/Z below the luma, (1-y)/(1-Z) otherwise
    // the ramp keeps luma strictly between 0 and 1, so the divisor is never 0
    // ------------------------------------------------------------------
    hmr_pkg::t_item r_s5_item;
    logic [16:0]    r_s5_num, r_s5_den;
    logic           w_below;

    assign w_below = r_s4_item.lvl < r_s4_item.luma;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_item <= r_s4_item;
            r_s5_num  <= w_below ? r_s4_item.lvl  : hmr_pkg::ONE - r_s4_item.lvl;
            r_s5_den  <= w_below ? r_s4_item.luma : hmr_pkg::ONE - r_s4_item.luma;
        end
    end

    // ------------------------------------------------------------------
    // divider pipeline
    // ------------------------------------------------------------------
    logic [16:0]    w_quo;
    hmr_pkg::t_item w_div_item;

    hmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s5_vld),
        .i_num   (r_s5_num),
        .i_den   (r_s5_den),
        .i_item  (r_s5_item),
        .o_vld   (w_div_vld),
        .o_quo   (w_quo),
        .o_item  (w_div_item)
    );

    // ------------------------------------------------------------------
    // stage 6: hcy chroma rescaled by the quotient
    // ------------------------------------------------------------------
    hmr_pkg::t_item r_s6_item;
    logic [16:0]    r_s6_chroma;
    logic [33:0]    w_cp;

    assign w_cp = 34'(w_div_item.sat) * 34'(w_quo);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_item   <= w_div_item;
            r_s6_chroma <= w_cp[32:16];
        end
    end

    // ------------------------------------------------------------------
    // stage 7: per-channel signed product, operands picked by model
    //   hsv: u * v, hsl: (ramp - 1/2) * C, hcy: (ramp - Z) * c
    // ------------------------------------------------------------------
    logic signed [35:0] r_s7_prod [3];
    logic [16:0]        r_s7_add;
    logic [7:0]         r_s7_alpha;
    logic signed [17:0] w_opa [3];
    logic signed [17:0] w_opb;
    logic [16:0]        w_add;

    always_comb begin
        w_opb = $signed({1'b0, r_s6_item.lvl});
        w_add = '0;
        for (int i = 0; i < 3; i++) begin
            w_opa[i] = $signed({1'b0, r_s6_item.hsv_u[i]});
        end
        unique case (r_s6_item.model)
            hmr_pkg::MODEL_HSL: begin
                w_opb = $signed({1'b0, r_s6_item.hsl_c});
                w_add = r_s6_item.lvl;
                for (int i = 0; i < 3; i++) begin
                    w_opa[i] = $signed({1'b0, r_s6_item.ramp[i]}) - HALF_S;
                end
            end
            hmr_pkg::MODEL_HCY: begin
                w_opb = $signed({1'b0, r_s6_chroma});
                w_add = r_s6_item.lvl;
                for (int i = 0; i < 3; i++) begin
                    w_opa[i] = $signed({1'b0, r_s6_item.ramp[i]})
                             - $signed({1'b0, r_s6_item.luma});
                end
            end
            default: begin
                // hsv, and the unused code
                w_opb = $signed({1'b0, r_s6_item.lvl});
            end
        endcase
    end

    for (genvar i = 0; i < 3; i++) begin : g_s7
        logic signed [35:0] w_ax, w_bx;
        assign w_ax = {{18{w_opa[i][17]}}, w_opa[i]};
        assign w_bx = {{18{w_opb[17]}}, w_opb};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s7_prod[i] <= w_ax * w_bx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_add   <= w_add;
            r_s7_alpha <= r_s6_item.alpha;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: truncate toward zero to q.16, add the level offset
    // ------------------------------------------------------------------
    logic signed [18:0] r_s8_ch [3];
    logic [7:0]         r_s8_alpha;

    for (genvar i = 0; i < 3; i++) begin : g_s8
        logic               w_neg;
        logic [35:0]        w_mag;
        logic signed [18:0] w_t;

        assign w_neg = r_s7_prod[i] < 0;
        assign w_mag = w_neg ? 36'(-r_s7_prod[i]) : 36'(r_s7_prod[i]);
        assign w_t   = $signed({2'b00, w_mag[32:16]});

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s8_ch[i] <= (w_neg ? -w_t : w_t) + $signed({2'b00, r_s7_add});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_alpha <= r_s7_alpha;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: floor(ch * 255) saturated, output register
    // ------------------------------------------------------------------
    logic [7:0] r_s9_rgb [3];
    logic [7:0] r_s9_alpha;

    for (genvar i = 0; i < 3; i++) begin : g_s9
        logic [25:0] w_x255;
        logic [9:0]  w_v;

        assign w_x255 = {r_s8_ch[i][17:0], 8'b0} - 26'(r_s8_ch[i][17:0]);
        assign w_v    = w_x255[25:16];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (r_s8_ch[i] <= 0) begin
                    r_s9_rgb[i] <= '0;
                end else if (w_v > 10'd255) begin
                    r_s9_rgb[i] <= 8'hff;
                end else begin
                    r_s9_rgb[i] <= w_v[7:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_alpha <= r_s8_alpha;
        end
    end

    assign o_pix.valid     = r_s9_vld;
    assign o_pix.red       = r_s9_rgb[0];
    assign o_pix.green     = r_s9_rgb[1];
    assign o_pix.blue      = r_s9_rgb[2];
    assign o_pix.alpha_out = r_s9_alpha;

endmodule
